[hw/rtl/cldr_pkg.sv]
`default_nettype none

package cldr_pkg;

    localparam int NUM_DIGITS = 12;
    localparam int C_DIGITS   = 14;

    // item modes
    localparam logic [2:0] MODE_READ   = 3'd0;
    localparam logic [2:0] MODE_WRITE  = 3'd1;
    localparam logic [2:0] MODE_ANNUN  = 3'd2;
    localparam logic [2:0] MODE_OFF    = 3'd3;
    localparam logic [2:0] MODE_TOGGLE = 3'd4;
    localparam logic [2:0] MODE_RENDER = 3'd5;

    // read of this group returns the annunciator word
    localparam logic [3:0] GRP_ANNUN = 4'd5;

    localparam logic [6:0] ASC_SPACE  = 7'h20;
    localparam logic [6:0] ASC_PERIOD = 7'h2e;
    localparam logic [6:0] ASC_COLON  = 7'h3a;
    localparam logic [6:0] ASC_COMMA  = 7'h2c;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  group_select;
        logic [55:0] cpu_c_in;
        logic [3:0]  position;
    } t_in_item;

    typedef struct packed {
        logic [55:0] cpu_c_out;
        logic        c_written;
        logic        display_on;
        logic [6:0]  char_code;
        logic [6:0]  punct_code;
    } t_out_item;

    // sel bit 0: A, bit 1: B, bit 2: C
    typedef struct packed {
        logic [2:0] sel;
        logic [3:0] cnt;
        logic       left;
    } t_xfer;

    typedef struct packed {
        logic       shift;
        logic       up;      // contents move toward the high position
        logic       load;    // store data at the entry end after the move
        logic [3:0] data;
    } t_lane_ctl;

    typedef struct packed {
        logic       en;
        logic       rd;
        logic [2:0] sel;
        logic [3:0] dig_a;
        logic [3:0] dig_b;
        logic       dig_c;
    } t_merge_step;

    function automatic t_xfer f_mk(input logic [2:0] sel, input logic [3:0] cnt,
                                   input logic left);
        t_xfer x;
        x.sel  = sel;
        x.cnt  = cnt;
        x.left = left;
        return x;
    endfunction

    function automatic t_xfer f_rd_xfer(input logic [3:0] n);
        t_xfer x;
        case (n)
            4'd0:    x = f_mk(3'd1, 4'd12, 1'b1);
            4'd1:    x = f_mk(3'd2, 4'd12, 1'b1);
            4'd2:    x = f_mk(3'd4, 4'd12, 1'b1);
            4'd3:    x = f_mk(3'd3, 4'd6,  1'b1);
            4'd4:    x = f_mk(3'd7, 4'd4,  1'b1);
            4'd5:    x = f_mk(3'd0, 4'd0,  1'b1);
            4'd6:    x = f_mk(3'd4, 4'd1,  1'b1);
            4'd7:    x = f_mk(3'd1, 4'd1,  1'b0);
            4'd8:    x = f_mk(3'd2, 4'd1,  1'b0);
            4'd9:    x = f_mk(3'd4, 4'd1,  1'b0);
            4'd10:   x = f_mk(3'd1, 4'd1,  1'b1);
            4'd11:   x = f_mk(3'd2, 4'd1,  1'b1);
            4'd12:   x = f_mk(3'd3, 4'd1,  1'b0);
            4'd13:   x = f_mk(3'd3, 4'd1,  1'b1);
            4'd14:   x = f_mk(3'd7, 4'd1,  1'b0);
            default: x = f_mk(3'd7, 4'd1,  1'b1);
        endcase
        return x;
    endfunction

    function automatic t_xfer f_wr_xfer(input logic [3:0] n);
        t_xfer x;
        case (n)
            4'd0:    x = f_mk(3'd1, 4'd12, 1'b1);
            4'd1:    x = f_mk(3'd2, 4'd12, 1'b1);
            4'd2:    x = f_mk(3'd4, 4'd12, 1'b1);
            4'd3:    x = f_mk(3'd3, 4'd6,  1'b1);
            4'd4:    x = f_mk(3'd7, 4'd4,  1'b1);
            4'd5:    x = f_mk(3'd3, 4'd6,  1'b0);
            4'd6:    x = f_mk(3'd7, 4'd4,  1'b0);
            4'd7:    x = f_mk(3'd1, 4'd1,  1'b1);
            4'd8:    x = f_mk(3'd2, 4'd1,  1'b1);
            4'd9:    x = f_mk(3'd4, 4'd1,  1'b1);
            4'd10:   x = f_mk(3'd1, 4'd1,  1'b0);
            4'd11:   x = f_mk(3'd2, 4'd1,  1'b0);
            4'd12:   x = f_mk(3'd4, 4'd1,  1'b0);
            4'd13:   x = f_mk(3'd3, 4'd1,  1'b0);
            4'd14:   x = f_mk(3'd7, 4'd1,  1'b1);
            default: x = f_mk(3'd7, 4'd1,  1'b0);
        endcase
        return x;
    endfunction

    function automatic logic [3:0] f_get_dig(input logic [55:0] w, input logic [3:0] idx);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 0; k < C_DIGITS; k++) begin
            if (idx == 4'(k)) d = w[4*k +: 4];
        end
        return d;
    endfunction

    function automatic logic [55:0] f_set_dig(input logic [55:0] w, input logic [3:0] idx,
                                              input logic [3:0] v);
        logic [55:0] r;
        r = w;
        for (int k = 0; k < C_DIGITS; k++) begin
            if (idx == 4'(k)) r[4*k +: 4] = v;
        end
        return r;
    endfunction

    // glyph base per row; rows 5..7 are blank
    function automatic logic [6:0] f_glyph(input logic [2:0] row, input logic [3:0] a);
        logic [6:0] g;
        case (row)
            3'd0:    g = 7'h40 + {3'd0, a};
            3'd1:    g = 7'h50 + {3'd0, a};
            3'd2:    g = 7'h20 + {3'd0, a};
            3'd3:    g = 7'h30 + {3'd0, a};
            3'd4:    g = 7'h60 + {3'd0, a};
            default: g = ASC_SPACE;
        endcase
        return g;
    endfunction

    function automatic logic [6:0] f_punct(input logic [1:0] p);
        logic [6:0] c;
        case (p)
            2'd0:    c = ASC_SPACE;
            2'd1:    c = ASC_PERIOD;
            2'd2:    c = ASC_COLON;
            default: c = ASC_COMMA;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cldr_lane.sv]
`default_nettype none

// One rotating digit register; one position move per cycle while shift is set.
module cldr_lane #(
    parameter int W = 4
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  cldr_pkg::t_lane_ctl     i_ctl,
    input  wire [3:0]               i_pos,
    output logic [W-1:0]            o_head_hi,
    output logic [W-1:0]            o_head_lo,
    output logic [W-1:0]            o_tap
);
    import cldr_pkg::*;

    logic [W-1:0] r_dig [NUM_DIGITS];
    logic [W-1:0] n_dig [NUM_DIGITS];

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) n_dig[i] = r_dig[i];
        if (i_ctl.shift) begin
            if (i_ctl.up) begin
                n_dig[0] = r_dig[NUM_DIGITS-1];
                for (int i = 1; i < NUM_DIGITS; i++) n_dig[i] = r_dig[i-1];
                if (i_ctl.load) n_dig[0] = i_ctl.data[W-1:0];
            end else begin
                n_dig[NUM_DIGITS-1] = r_dig[0];
                for (int i = 0; i < NUM_DIGITS - 1; i++) n_dig[i] = r_dig[i+1];
                if (i_ctl.load) n_dig[NUM_DIGITS-1] = i_ctl.data[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DIGITS; i++) r_dig[i] <= '0;
        end else begin
            for (int i = 0; i < NUM_DIGITS; i++) r_dig[i] <= n_dig[i];
        end
    end

    assign o_head_hi = r_dig[NUM_DIGITS-1];
    assign o_head_lo = r_dig[0];
    assign o_tap     = (i_pos < 4'(NUM_DIGITS)) ? r_dig[i_pos] : '0;

endmodule

`default_nettype wire

[hw/rtl/cldr_merge.sv]
`default_nettype none

// Packs lane digits into the C word (read) or hands C digits to the lanes (write).
module cldr_merge (
    input  wire                     i_clk,
    input  wire                     i_load,
    input  wire [55:0]              i_word,
    input  cldr_pkg::t_merge_step   i_step,
    output logic [55:0]             o_word,
    output logic [3:0]              o_wr_a,
    output logic [3:0]              o_wr_b,
    output logic [3:0]              o_wr_c
);
    import cldr_pkg::*;

    logic [55:0] r_word, n_word;
    logic [3:0]  r_base, n_base;
    logic [3:0]  idx_a, idx_b, idx_c;
    logic [1:0]  pop;

    // A first, then B, then C within one step
    assign idx_a = r_base;
    assign idx_b = r_base + {3'd0, i_step.sel[0]};
    assign idx_c = r_base + {3'd0, i_step.sel[0]} + {3'd0, i_step.sel[1]};
    assign pop   = {1'b0, i_step.sel[0]} + {1'b0, i_step.sel[1]} + {1'b0, i_step.sel[2]};

    always_comb begin
        n_word = r_word;
        n_base = r_base;
        if (i_load) begin
            n_word = i_word;
            n_base = 4'd0;
        end else if (i_step.en) begin
            n_base = r_base + {2'd0, pop};
            if (i_step.rd) begin
                if (i_step.sel[0]) n_word = f_set_dig(n_word, idx_a, i_step.dig_a);
                if (i_step.sel[1]) n_word = f_set_dig(n_word, idx_b, i_step.dig_b);
                if (i_step.sel[2]) n_word = f_set_dig(n_word, idx_c, {3'd0, i_step.dig_c});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_base <= n_base;
    end

    assign o_word = r_word;
    assign o_wr_a = f_get_dig(r_word, idx_a);
    assign o_wr_b = f_get_dig(r_word, idx_b);
    assign o_wr_c = f_get_dig(r_word, idx_c);

endmodule

`default_nettype wire

[hw/rtl/calculator_lcd_digit_registers.sv]
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_in_data  (t_in_item)
// output    out        o_out_valid / i_out_stall o_out_data (t_out_item)
//
// One item at a time. A group read/write is accepted, then makes one digit step per
// cycle (1..12 steps, all selected lanes move together), then finishes; other modes
// go from accept straight to finish. The group table sets the step count.
// Reset (synchronous, i_rst_n low) clears all digit lanes, annunciators and
// the display flag. A result held by i_out_stall stays put; a new item is
// still taken meanwhile and waits in the finish state for the output slot.
module calculator_lcd_digit_registers (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  cldr_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output cldr_pkg::t_out_item   o_out_data
);
    import cldr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [2:0]  r_mode;
    logic [3:0]  r_n;
    logic [3:0]  r_pos;
    logic [2:0]  r_sel;
    logic        r_left;
    logic        r_rd;
    logic [3:0]  r_cnt, n_cnt;
    logic [11:0] r_annun, n_annun;
    logic        r_enabled, n_enabled;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic        in_xfer;     // input transfer this cycle
    logic        out_free;    // output slot can take a result this cycle
    t_xfer       xf;
    logic        is_group;

    t_lane_ctl   ctl_a, ctl_b, ctl_c;
    t_merge_step step;
    logic [55:0] word;
    logic [3:0]  wr_a, wr_b, wr_c;
    logic [3:0]  hi_a, lo_a, tap_a, hi_b, lo_b, tap_b;
    logic        hi_c, lo_c, tap_c;
    logic        lane_up;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign xf = (i_in_data.mode == MODE_READ) ? f_rd_xfer(i_in_data.group_select)
                                              : f_wr_xfer(i_in_data.group_select);
    assign is_group = (i_in_data.mode == MODE_WRITE) ||
                      ((i_in_data.mode == MODE_READ) && (i_in_data.group_select != GRP_ANNUN));

    // reads rotate toward the read end, writes away from the write end
    assign lane_up = r_rd ? r_left : !r_left;

    always_comb begin
        ctl_a.shift = (r_state == S_RUN) && r_sel[0];
        ctl_b.shift = (r_state == S_RUN) && r_sel[1];
        ctl_c.shift = (r_state == S_RUN) && r_sel[2];
        ctl_a.up = lane_up;
        ctl_b.up = lane_up;
        ctl_c.up = lane_up;
        ctl_a.load = !r_rd;
        ctl_b.load = !r_rd;
        ctl_c.load = !r_rd;
        ctl_a.data = wr_a;
        ctl_b.data = wr_b;
        ctl_c.data = wr_c;
        step.en    = (r_state == S_RUN);
        step.rd    = r_rd;
        step.sel   = r_sel;
        step.dig_a = r_left ? hi_a : lo_a;
        step.dig_b = r_left ? hi_b : lo_b;
        step.dig_c = r_left ? hi_c : lo_c;
    end

    cldr_lane #(.W(4)) u_lane_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_a), .i_pos(r_pos),
        .o_head_hi(hi_a), .o_head_lo(lo_a), .o_tap(tap_a)
    );

    cldr_lane #(.W(4)) u_lane_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_b), .i_pos(r_pos),
        .o_head_hi(hi_b), .o_head_lo(lo_b), .o_tap(tap_b)
    );

    cldr_lane #(.W(1)) u_lane_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_c), .i_pos(r_pos),
        .o_head_hi(hi_c), .o_head_lo(lo_c), .o_tap(tap_c)
    );

    cldr_merge u_merge (
        .i_clk(i_clk), .i_load(in_xfer), .i_word(i_in_data.cpu_c_in), .i_step(step),
        .o_word(word), .o_wr_a(wr_a), .o_wr_b(wr_b), .o_wr_c(wr_c)
    );

    // sequencer and result assembly
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_annun     = r_annun;
        n_enabled   = r_enabled;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cnt   = xf.cnt;
                    n_state = is_group ? S_RUN : S_FIN;
                end
            end
            S_RUN: begin
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd1) n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    if (r_mode == MODE_OFF)    n_enabled = 1'b0;
                    if (r_mode == MODE_TOGGLE) n_enabled = !r_enabled;
                    if (r_mode == MODE_ANNUN)  n_annun   = word[11:0];
                    n_out.cpu_c_out  = word;
                    if ((r_mode == MODE_READ) && (r_n == GRP_ANNUN))
                        n_out.cpu_c_out[11:0] = r_annun;
                    n_out.c_written  = (r_mode == MODE_READ);
                    n_out.display_on = n_enabled;
                    n_out.char_code  = 7'd0;
                    n_out.punct_code = 7'd0;
                    if (r_mode == MODE_RENDER) begin
                        n_out.char_code  = ASC_SPACE;
                        n_out.punct_code = ASC_SPACE;
                        if (r_enabled && (r_pos < 4'(NUM_DIGITS))) begin
                            n_out.char_code  = f_glyph({tap_c, tap_b[1:0]}, tap_a);
                            n_out.punct_code = f_punct(tap_b[3:2]);
                        end
                    end
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 4'd0;
            r_annun     <= 12'd0;
            r_enabled   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_annun     <= n_annun;
            r_enabled   <= n_enabled;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_xfer) begin
            r_mode <= i_in_data.mode;
            r_n    <= i_in_data.group_select;
            r_pos  <= i_in_data.position;
            r_sel  <= is_group ? xf.sel : 3'd0;
            r_left <= xf.left;
            r_rd   <= (i_in_data.mode == MODE_READ);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[hw/rtl/cldr_checker.sv]
`default_nettype none

module cldr_checker (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_in_valid,
    input wire                   o_in_stall,
    input cldr_pkg::t_in_item    i_in_data,
    input wire                   o_out_valid,
    input wire                   i_out_stall,
    input cldr_pkg::t_out_item   o_out_data
);
    import cldr_pkg::*;

    // one item in flight: the input side closes right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after a transfer");

    // a new result follows a busy cycle
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without preceding work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // a dark display never shows a glyph
    a_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.display_on) |->
        ((o_out_data.char_code == 7'd0) || (o_out_data.char_code == ASC_SPACE)))
        else $error("glyph while display off");

    a_punct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        ((o_out_data.punct_code == 7'd0) || (o_out_data.punct_code == ASC_SPACE) ||
         (o_out_data.punct_code == ASC_PERIOD) || (o_out_data.punct_code == ASC_COLON) ||
         (o_out_data.punct_code == ASC_COMMA)))
        else $error("bad punctuation code");

endmodule

bind calculator_lcd_digit_registers cldr_checker u_cldr_checker (.*);

`default_nettype wire
